// ----- rtl/core/msb_first_bit_packer_defines.svh -----
// ----------------------------------------------------------------------------
// msb_first_bit_packer_defines.svh
// Assertion macros for the bit packer RTL.
// ----------------------------------------------------------------------------
`ifndef MSB_FIRST_BIT_PACKER_DEFINES_SVH
`define MSB_FIRST_BIT_PACKER_DEFINES_SVH

// same-cycle implication, sampled on clk, off during reset
`define MFBP_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, sampled on clk, off during reset
`define MFBP_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- rtl/core/mfbp_pkg.sv -----
// ----------------------------------------------------------------------------
// mfbp_pkg
// Constants, codes and controller/datapath interface types of the bit packer.
// ----------------------------------------------------------------------------
package mfbp_pkg;

    localparam int MAX_FIELD_BITS = 64;
    localparam int BYTE_BITS      = 8;
    localparam int VALUE_W        = 64;
    localparam int LEN_W          = 7;
    localparam int OP_W           = 2;
    localparam int ACC_W          = MAX_FIELD_BITS + BYTE_BITS;
    localparam int PEND_W         = BYTE_BITS - 1;
    localparam int PC_W           = $clog2(BYTE_BITS);
    localparam int MAX_BYTES      = (MAX_FIELD_BITS + BYTE_BITS - 1) / BYTE_BITS;
    localparam int CNT_W          = $clog2(MAX_BYTES + 1);
    localparam int TOT_W          = $clog2(MAX_FIELD_BITS + BYTE_BITS);

    typedef enum logic [OP_W-1:0] {
        OP_PUSH  = 2'd0,
        OP_FLUSH = 2'd1,
        OP_CLEAR = 2'd2
    } op_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_ALIGN,
        ST_EMIT,
        ST_COMMIT
    } state_t;

    typedef struct packed {
        logic capture;
        logic align;
        logic shift;
        logic commit;
    } dp_cmd_t;

    typedef struct packed {
        logic has_bytes;
        logic last_byte;
    } dp_status_t;

endpackage

// ----- rtl/core/mfbp_datapath.sv -----
// ----------------------------------------------------------------------------
// mfbp_datapath
// Request capture, bit stream alignment, byte shift-out and pending bits.
// ----------------------------------------------------------------------------
module mfbp_datapath
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  mfbp_pkg::dp_cmd_t             cmd,
    output mfbp_pkg::dp_status_t          status,
    input  logic [mfbp_pkg::OP_W-1:0]     op,
    input  logic [mfbp_pkg::VALUE_W-1:0]  field_value,
    input  logic [mfbp_pkg::LEN_W-1:0]    field_length,
    output logic [mfbp_pkg::BYTE_BITS-1:0] out_byte,
    output logic                          last_of_run
);

    logic [mfbp_pkg::OP_W-1:0]           op_reg;
    logic [mfbp_pkg::MAX_FIELD_BITS-1:0] value_reg;
    logic [mfbp_pkg::LEN_W-1:0]          len_reg;
    logic [mfbp_pkg::ACC_W-1:0]          acc_reg;
    logic [mfbp_pkg::ACC_W-1:0]          acc_next;
    logic [mfbp_pkg::CNT_W-1:0]          count_reg;
    logic [mfbp_pkg::CNT_W-1:0]          count_next;
    logic [mfbp_pkg::PEND_W-1:0]         pend_reg;
    logic [mfbp_pkg::PC_W-1:0]           pc_reg;
    logic [mfbp_pkg::PC_W-1:0]           pc_next;

    logic [mfbp_pkg::LEN_W-1:0]          len_sat;
    logic [mfbp_pkg::MAX_FIELD_BITS-1:0] aligned;
    logic [mfbp_pkg::BYTE_BITS-1:0]      pend_left;
    logic [mfbp_pkg::ACC_W-1:0]          stream;
    logic [mfbp_pkg::TOT_W-1:0]          total;

    assign len_sat = (field_length > mfbp_pkg::LEN_W'(mfbp_pkg::MAX_FIELD_BITS))
                   ? mfbp_pkg::LEN_W'(mfbp_pkg::MAX_FIELD_BITS) : field_length;

    // new bits left-aligned, placed right after the pending bits
    assign aligned   = value_reg << (mfbp_pkg::LEN_W'(mfbp_pkg::MAX_FIELD_BITS) - len_reg);
    assign pend_left = {pend_reg, 1'b0};
    assign stream    = {aligned, mfbp_pkg::BYTE_BITS'(0)} >> pc_reg;
    assign total     = mfbp_pkg::TOT_W'(pc_reg) + mfbp_pkg::TOT_W'(len_reg);

    always_comb
    begin
        acc_next   = {pend_left, mfbp_pkg::MAX_FIELD_BITS'(0)};
        count_next = '0;
        pc_next    = pc_reg;
        unique case (mfbp_pkg::op_t'(op_reg))
            mfbp_pkg::OP_PUSH:
            begin
                acc_next   = {pend_left, mfbp_pkg::MAX_FIELD_BITS'(0)} | stream;
                count_next = mfbp_pkg::CNT_W'(total >> mfbp_pkg::PC_W);
                pc_next    = total[mfbp_pkg::PC_W-1:0];
            end
            mfbp_pkg::OP_FLUSH:
            begin
                count_next = (pc_reg != '0) ? mfbp_pkg::CNT_W'(1) : '0;
                pc_next    = '0;
            end
            mfbp_pkg::OP_CLEAR:
            begin
                acc_next = '0;
                pc_next  = '0;
            end
            default:
            begin
                pc_next = pc_reg;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            op_reg    <= op;
            value_reg <= field_value[mfbp_pkg::MAX_FIELD_BITS-1:0];
            len_reg   <= len_sat;
        end
        if (cmd.align)
        begin
            acc_reg <= acc_next;
        end
        else if (cmd.shift)
        begin
            acc_reg <= acc_reg << mfbp_pkg::BYTE_BITS;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            pend_reg  <= '0;
            pc_reg    <= '0;
        end
        else
        begin
            if (cmd.align)
            begin
                count_reg <= count_next;
                pc_reg    <= pc_next;
            end
            else if (cmd.shift)
            begin
                count_reg <= count_reg - mfbp_pkg::CNT_W'(1);
            end
            // leftover bits sit left-aligned at the top once all bytes are out
            if (cmd.commit)
            begin
                pend_reg <= acc_reg[mfbp_pkg::ACC_W-1 -: mfbp_pkg::PEND_W];
            end
        end
    end

    assign out_byte         = acc_reg[mfbp_pkg::ACC_W-1 -: mfbp_pkg::BYTE_BITS];
    assign last_of_run      = (count_reg == mfbp_pkg::CNT_W'(1));
    assign status.has_bytes = (count_reg != '0);
    assign status.last_byte = (count_reg == mfbp_pkg::CNT_W'(1));

endmodule

// ----- rtl/core/mfbp_ctrl.sv -----
// ----------------------------------------------------------------------------
// mfbp_ctrl
// Sequencer: capture, align, emit bytes, commit pending bits.
// ----------------------------------------------------------------------------
module mfbp_ctrl
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_stall,
    output logic                 out_valid,
    input  logic                 out_stall,
    input  mfbp_pkg::dp_status_t status,
    output mfbp_pkg::dp_cmd_t    cmd
);

    mfbp_pkg::state_t state_reg;
    mfbp_pkg::state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= mfbp_pkg::ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next  = state_reg;
        cmd         = '0;
        in_stall    = 1'b1;
        out_valid   = 1'b0;
        unique case (state_reg)
            mfbp_pkg::ST_IDLE:
            begin
                in_stall = 1'b0;
                if (in_valid)
                begin
                    cmd.capture = 1'b1;
                    state_next  = mfbp_pkg::ST_ALIGN;
                end
            end
            mfbp_pkg::ST_ALIGN:
            begin
                cmd.align  = 1'b1;
                state_next = mfbp_pkg::ST_EMIT;
            end
            mfbp_pkg::ST_EMIT:
            begin
                if (!status.has_bytes)
                begin
                    state_next = mfbp_pkg::ST_COMMIT;
                end
                else
                begin
                    out_valid = 1'b1;
                    if (!out_stall)
                    begin
                        cmd.shift = 1'b1;
                        if (status.last_byte)
                        begin
                            state_next = mfbp_pkg::ST_COMMIT;
                        end
                    end
                end
            end
            mfbp_pkg::ST_COMMIT:
            begin
                cmd.commit = 1'b1;
                state_next = mfbp_pkg::ST_IDLE;
            end
            default:
            begin
                state_next = mfbp_pkg::ST_IDLE;
            end
        endcase
    end

endmodule

// ----- rtl/core/msb_first_bit_packer.sv -----
// ----------------------------------------------------------------------------
// msb_first_bit_packer
// Packs variable-length bit fields MSB first into a byte stream.
// ----------------------------------------------------------------------------
// One request at a time. A push appends the low field_length bits (capped at
// 64) after the pending bits and sends every completed byte, one per cycle
// while out_stall is low, with last_of_run on the final one; a flush sends
// the pending bits padded with zeros on the right; a clear drops them. A
// request is captured, aligned into the 72-bit accumulator, emits its bytes
// from the top of it and commits the pending bits before the next is taken.
module msb_first_bit_packer
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_stall,
    input  logic [mfbp_pkg::OP_W-1:0]     op,
    input  logic [mfbp_pkg::VALUE_W-1:0]  field_value,
    input  logic [mfbp_pkg::LEN_W-1:0]    field_length,
    output logic                          out_valid,
    input  logic                          out_stall,
    output logic [mfbp_pkg::BYTE_BITS-1:0] out_byte,
    output logic                          last_of_run
);

    `include "msb_first_bit_packer_defines.svh"

    mfbp_pkg::dp_cmd_t    cmd;
    mfbp_pkg::dp_status_t status;

    mfbp_ctrl u_ctrl
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .status    (status),
        .cmd       (cmd)
    );

    mfbp_datapath u_datapath
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .status       (status),
        .op           (op),
        .field_value  (field_value),
        .field_length (field_length),
        .out_byte     (out_byte),
        .last_of_run  (last_of_run)
    );

    `MFBP_ASSERT_SAME(a_no_request_while_emitting, out_valid, in_stall, "request taken during emit")
    `MFBP_ASSERT_NEXT(a_last_ends_run, out_valid && !out_stall && last_of_run, !out_valid, "byte after last of run")
    `MFBP_ASSERT_NEXT(a_request_then_busy, in_valid && !in_stall, in_stall && !out_valid, "no alignment cycle after request")

endmodule
